/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the access filter RTL.
// Each macro wraps one clocked concurrent assertion with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ipacl_pkg.sv */
// Package for the IPv4 CIDR access filter: sizes, codes, table command structs.
// No dependencies; used by ipacl_table, ip_cidr_access_filter and the bench.
package ipacl_pkg;

  localparam int LIST_ENTRIES = 16;
  localparam int IDX_W = (LIST_ENTRIES > 1) ? $clog2(LIST_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_ENTRIES - 1);
  localparam logic [5:0] PLEN_MAX = 6'd32;

  localparam logic LIST_ALLOW = 1'b0;
  localparam logic LIST_BLOCK = 1'b1;

  typedef enum logic [2:0] {
    FN_CHECK     = 3'd0,
    FN_ADD_ALLOW = 3'd1,
    FN_ADD_BLOCK = 3'd2,
    FN_REM_ALLOW = 3'd3,
    FN_REM_BLOCK = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BLOCKED       = 3'd1,
    ST_NOT_ALLOWED   = 3'd2,
    ST_NO_TOKEN      = 3'd3,
    ST_INVALID_TOKEN = 3'd4,
    ST_FULL          = 3'd5,
    ST_NOT_FOUND     = 3'd6
  } status_t;

  typedef struct packed {
    logic             en;
    logic             list;
    logic [IDX_W-1:0] idx;
  } tbl_rd_t;

  typedef struct packed {
    logic             en;
    logic             load;      // store key address and prefix
    logic             list;
    logic [IDX_W-1:0] idx;
    logic             used_val;
  } tbl_wr_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             used;
    logic             pfx_hit;
    logic             exact_hit;
  } tbl_cmp_t;

  // Network mask for a prefix length; lengths 32 and up give all ones.
  function automatic logic [31:0] pfx_mask(input logic [5:0] plen);
    logic [31:0] m;
    for (int j = 0; j < 32; j++) begin
      m[j] = (6'(31 - j) < plen);
    end
    return m;
  endfunction

  function automatic status_t tok_status(input logic chk_en, input logic present,
                                         input logic accepted);
    status_t s;
    if (chk_en && !present) begin
      s = ST_NO_TOKEN;
    end else if (chk_en && !accepted) begin
      s = ST_INVALID_TOKEN;
    end else begin
      s = ST_OK;
    end
    return s;
  endfunction

endpackage

/* hw/rtl/ipacl_if.sv */
// Valid/ready channel interfaces for the access filter request and response.
// No dependencies; the port widths are written out directly.
interface ipacl_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] address;
  logic [5:0]  pfx_len;
  logic        ip_present;
  logic        token_present;
  logic        token_accepted;

  modport source (output valid, func, address, pfx_len, ip_present, token_present,
                  token_accepted, input ready);
  modport sink (input valid, func, address, pfx_len, ip_present, token_present,
                token_accepted, output ready);
endinterface

interface ipacl_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       allow_list_on;
  logic       block_list_on;

  modport source (output valid, status, allow_list_on, block_list_on, input ready);
  modport sink (input valid, status, allow_list_on, block_list_on, output ready);
endinterface

/* hw/rtl/ipacl_table.sv */
// Entry store for both lists plus the shared entry comparator.
// Depends on ipacl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ipacl_table import ipacl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tbl_rd_t     rd,
  input  tbl_wr_t     wr,
  input  logic [31:0] key_addr,
  input  logic [5:0]  key_plen,
  output tbl_cmp_t    cmp
);

  logic [31:0] net_mem  [2][LIST_ENTRIES];
  logic [5:0]  plen_mem [2][LIST_ENTRIES];

  logic [LIST_ENTRIES-1:0] used_r [2];

  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_used_r;
  logic [31:0]      rd_net_r;
  logic [5:0]       rd_plen_r;
  logic [31:0]      mask;

  always_ff @(posedge clk) begin
    if (wr.en && wr.load) begin
      net_mem[wr.list][wr.idx]  <= key_addr;
      plen_mem[wr.list][wr.idx] <= key_plen;
    end
    if (rd.en) begin
      rd_net_r  <= net_mem[rd.list][rd.idx];
      rd_plen_r <= plen_mem[rd.list][rd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r[0] <= '0;
      used_r[1] <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        used_r[wr.list][wr.idx] <= wr.used_val;
      end
      rd_vld_r <= rd.en;
    end
    rd_idx_r  <= rd.idx;
    rd_used_r <= used_r[rd.list][rd.idx];
  end

  // Compare stage: the entry read last cycle against the held key.
  assign mask          = pfx_mask(rd_plen_r);
  assign cmp.vld       = rd_vld_r;
  assign cmp.idx       = rd_idx_r;
  assign cmp.used      = rd_used_r;
  assign cmp.pfx_hit   = rd_used_r && (rd_plen_r <= PLEN_MAX) &&
                         (((rd_net_r ^ key_addr) & mask) == 32'd0);
  assign cmp.exact_hit = rd_used_r && (rd_net_r == key_addr) && (rd_plen_r == key_plen);

  `ASSERT_ALWAYS(a_no_rd_on_wr, clk, rst_n, !(wr.en && rd.en), "table read during write")

endmodule

/* hw/rtl/ip_cidr_access_filter.sv */
// IPv4 CIDR access filter top level: request sequencer, list flags, result register.
// Depends on ipacl_pkg, ipacl_if, ipacl_table and assert_macros.svh.
//
// A request either adds or removes an allow/block entry or checks a client; other
// function codes return OK without a scan. The entries of a list are walked one per
// cycle through the single table read port and comparator: S_SCAN issues the reads,
// S_WAIT takes the last compare and S_EVAL decides. A request that needs no scan
// goes straight to S_DONE. The input is ready only between requests; a finished
// result sits in the output register, so the next request can be taken while the
// previous result waits. The token check enable register may be written only while
// no request is in flight.
`include "assert_macros.svh"

module ip_cidr_access_filter import ipacl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  ipacl_in_if.sink     in_chan,
  ipacl_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_EVAL,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  func_t            func_r, func_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [5:0]       plen_r, plen_nxt;
  logic             ipp_r, ipp_nxt;
  logic             tokp_r, tokp_nxt;
  logic             toka_r, toka_nxt;
  logic             list_r, list_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             hit_r, hit_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] found_idx_r, found_idx_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             any_used_r, any_used_nxt;
  status_t          res_r, res_nxt;
  logic             allow_on_r, allow_on_nxt;
  logic             block_on_r, block_on_nxt;
  logic             tok_en_r, tok_en_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic             out_allow_r, out_allow_nxt;
  logic             out_block_r, out_block_nxt;

  tbl_rd_t  tbl_rd;
  tbl_wr_t  tbl_wr;
  tbl_cmp_t cmp;

  ipacl_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (tbl_rd),
    .wr       (tbl_wr),
    .key_addr (addr_r),
    .key_plen (plen_r),
    .cmp      (cmp)
  );

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.allow_list_on = out_allow_r;
  assign out_chan.block_list_on = out_block_r;

  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    addr_nxt       = addr_r;
    plen_nxt       = plen_r;
    ipp_nxt        = ipp_r;
    tokp_nxt       = tokp_r;
    toka_nxt       = toka_r;
    list_nxt       = list_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    found_idx_nxt  = found_idx_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    any_used_nxt   = any_used_r;
    res_nxt        = res_r;
    allow_on_nxt   = allow_on_r;
    block_on_nxt   = block_on_r;
    tok_en_nxt     = cfg_wr_en ? cfg_wr_data : tok_en_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_allow_nxt  = out_allow_r;
    out_block_nxt  = out_block_r;
    tbl_rd         = '{en: 1'b0, list: list_r, idx: idx_r};
    tbl_wr         = '{en: 1'b0, load: 1'b0, list: list_r, idx: idx_r, used_val: 1'b0};

    // Collect compare results as entries land
    if (cmp.vld) begin
      if (cmp.pfx_hit) begin
        hit_nxt = 1'b1;
      end
      if (cmp.used) begin
        any_used_nxt = 1'b1;
      end
      if (cmp.exact_hit && !found_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = cmp.idx;
      end
      if (!cmp.used && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = cmp.idx;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          func_nxt     = func_t'(in_chan.func);
          addr_nxt     = in_chan.address;
          plen_nxt     = in_chan.pfx_len;
          ipp_nxt      = in_chan.ip_present;
          tokp_nxt     = in_chan.token_present;
          toka_nxt     = in_chan.token_accepted;
          idx_nxt      = '0;
          hit_nxt      = 1'b0;
          found_nxt    = 1'b0;
          free_nxt     = 1'b0;
          any_used_nxt = 1'b0;
          res_nxt      = ST_OK;
          state_nxt    = S_SCAN;
          case (func_t'(in_chan.func))
            FN_CHECK: begin
              if (block_on_r && in_chan.ip_present) begin
                list_nxt = LIST_BLOCK;
              end else if (allow_on_r && in_chan.ip_present) begin
                list_nxt = LIST_ALLOW;
              end else begin
                res_nxt   = tok_status(tok_en_r, in_chan.token_present,
                                       in_chan.token_accepted);
                state_nxt = S_DONE;
              end
            end
            FN_ADD_ALLOW, FN_REM_ALLOW: list_nxt = LIST_ALLOW;
            FN_ADD_BLOCK, FN_REM_BLOCK: list_nxt = LIST_BLOCK;
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        tbl_rd.en = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_WAIT;
        end
      end

      S_WAIT: state_nxt = S_EVAL;

      S_EVAL: begin
        state_nxt = S_DONE;
        case (func_r)
          FN_CHECK: begin
            if (list_r == LIST_BLOCK) begin
              if (hit_r) begin
                res_nxt = ST_BLOCKED;
              end else if (allow_on_r && ipp_r) begin
                // block list clean, go walk the allow list
                list_nxt     = LIST_ALLOW;
                idx_nxt      = '0;
                hit_nxt      = 1'b0;
                found_nxt    = 1'b0;
                free_nxt     = 1'b0;
                any_used_nxt = 1'b0;
                state_nxt    = S_SCAN;
              end else begin
                res_nxt = tok_status(tok_en_r, tokp_r, toka_r);
              end
            end else begin
              res_nxt = hit_r ? tok_status(tok_en_r, tokp_r, toka_r) : ST_NOT_ALLOWED;
            end
          end
          FN_ADD_ALLOW, FN_ADD_BLOCK: begin
            if (found_r) begin
              res_nxt = ST_OK;
            end else if (free_r) begin
              tbl_wr = '{en: 1'b1, load: 1'b1, list: list_r, idx: free_idx_r,
                         used_val: 1'b1};
              if (list_r == LIST_BLOCK) begin
                block_on_nxt = 1'b1;
              end else begin
                allow_on_nxt = 1'b1;
              end
              res_nxt = ST_OK;
            end else begin
              res_nxt = ST_FULL;
            end
          end
          FN_REM_ALLOW, FN_REM_BLOCK: begin
            if (found_r) begin
              tbl_wr  = '{en: 1'b1, load: 1'b0, list: list_r, idx: found_idx_r,
                          used_val: 1'b0};
              res_nxt = ST_OK;
            end else begin
              // an empty list turns off on a failed remove
              if (!any_used_r) begin
                if (list_r == LIST_BLOCK) begin
                  block_on_nxt = 1'b0;
                end else begin
                  allow_on_nxt = 1'b0;
                end
              end
              res_nxt = ST_NOT_FOUND;
            end
          end
          default: res_nxt = ST_OK;
        endcase
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_allow_nxt  = allow_on_r;
          out_block_nxt  = block_on_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      allow_on_r  <= 1'b0;
      block_on_r  <= 1'b0;
      tok_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      allow_on_r  <= allow_on_nxt;
      block_on_r  <= block_on_nxt;
      tok_en_r    <= tok_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    addr_r       <= addr_nxt;
    plen_r       <= plen_nxt;
    ipp_r        <= ipp_nxt;
    tokp_r       <= tokp_nxt;
    toka_r       <= toka_nxt;
    list_r       <= list_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    any_used_r   <= any_used_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_allow_r  <= out_allow_nxt;
    out_block_r  <= out_block_nxt;
  end

  `ASSERT_ALWAYS(a_cmp_in_scan, clk, rst_n,
                 !cmp.vld || state_r == S_SCAN || state_r == S_WAIT,
                 "compare result outside a scan")
  `ASSERT_ALWAYS(a_blocked_flag, clk, rst_n,
                 !(state_r == S_DONE && res_r == ST_BLOCKED) || block_on_r,
                 "blocked result with block list off")
  `ASSERT_NEXT(a_add_sets_flag, clk, rst_n,
               state_r == S_EVAL && tbl_wr.en && tbl_wr.used_val,
               (list_r == LIST_BLOCK) ? block_on_r : allow_on_r,
               "add did not enable its list")

endmodule

/* sim/tb_ip_cidr_access_filter.sv */
`timescale 1ns / 100ps
// Self-checking bench for ip_cidr_access_filter: add/remove/check requests with a
// built-in predictor of both lists, their flags and the token gate.
// Depends on ipacl_pkg, ipacl_in_if/ipacl_out_if and the filter RTL.
module tb_ip_cidr_access_filter;
  import ipacl_pkg::*;

  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST  = 3'd7;
  localparam int RAND_PHASES   = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int SETTLE_CYCLES = 60;
  localparam int LIMIT_NS      = 2_000_000;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_mix_t;
  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SLOW} rx_mode_t;

  // Percent cut points: check, add allow, add block, remove allow, remove block, spare.
  localparam int FUNC_CUTS [3][5] = '{'{40, 62, 84, 90, 96},
                                      '{50, 62, 74, 85, 96},
                                      '{40, 45, 50, 73, 96}};

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] address;
    logic [5:0]  pfx_len;
    logic        ip_present;
    logic        token_present;
    logic        token_accepted;
  } acl_req_t;

  typedef struct packed {
    status_t status;
    logic    allow_on;
    logic    block_on;
  } acl_result_t;

  typedef struct packed {
    logic        set_cfg;
    logic        cfg_val;
    acl_req_t    req;
    logic        typed;
    acl_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  ipacl_in_if  in_chan();
  ipacl_out_if out_chan();

  ip_cidr_access_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan    (in_chan),
    .out_chan   (out_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of both tables, their flags and the token gate
  logic        ent_used [2][LIST_ENTRIES];
  logic [31:0] ent_net  [2][LIST_ENTRIES];
  logic [5:0]  ent_plen [2][LIST_ENTRIES];
  logic        list_on  [2];
  logic        tok_check_on;

  acl_result_t verdict_q [$];
  int          mismatches = 0;
  int          burst_left = 0;
  logic [31:0] net_pool [8];

  dir_row_t dir_rows [26] = '{
    '{1'b0, 1'b0, '{FN_CHECK,     32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b0, 1'b0}},
    '{1'b0, 1'b0, '{FN_REM_ALLOW, 32'h0A00_0000, 6'd8,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_NOT_FOUND, 1'b0, 1'b0}},
    '{1'b0, 1'b0, '{FN_REM_BLOCK, 32'h0A00_0000, 6'd8,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_NOT_FOUND, 1'b0, 1'b0}},
    '{1'b0, 1'b0, '{FN_ADD_ALLOW, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b0}},
    // duplicate add
    '{1'b0, 1'b0, '{FN_ADD_ALLOW, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b0}},
    '{1'b0, 1'b0, '{FN_ADD_ALLOW, 32'hFFFF_FFFE, 6'd32, 1'b0, 1'b1, 1'b1}, 1'b1,
      '{ST_OK, 1'b1, 1'b0}},
    '{1'b0, 1'b0, '{FN_CHECK,     32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_NOT_ALLOWED, 1'b1, 1'b0}},
    // unknown client skips the lists
    '{1'b0, 1'b0, '{FN_CHECK,     32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b0}},
    '{1'b0, 1'b0, '{FN_CHECK,     32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b0}},
    '{1'b0, 1'b0, '{FN_ADD_BLOCK, 32'hC0A8_0000, 6'd16, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_ADD_ALLOW, 32'hC0A8_0000, 6'd16, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    // block wins over allow
    '{1'b0, 1'b0, '{FN_CHECK,     32'hC0A8_1234, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_BLOCKED, 1'b1, 1'b1}},
    // prefixes past /32 are stored but never match
    '{1'b0, 1'b0, '{FN_ADD_BLOCK, 32'h0A00_0000, 6'd33, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_CHECK,     32'h0A00_0000, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, 1'b0, '{FN_ADD_BLOCK, 32'h0A00_0000, 6'd63, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    // /0 matches everything
    '{1'b0, 1'b0, '{FN_ADD_ALLOW, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_CHECK,     32'h0102_0304, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{1'b0, 1'b0, '{FN_REM_ALLOW, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    // host bits make a different entry
    '{1'b0, 1'b0, '{FN_REM_BLOCK, 32'hC0A8_0001, 6'd16, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_NOT_FOUND, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_SPARE_FIRST, 32'h1234_5678, 6'd32, 1'b1, 1'b1, 1'b1}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_SPARE_LAST,  32'hFFFF_FFFF, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    '{1'b1, 1'b1, '{FN_CHECK,     32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b1}, 1'b1,
      '{ST_NO_TOKEN, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_CHECK,     32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b0}, 1'b1,
      '{ST_INVALID_TOKEN, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_CHECK,     32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 1'b1}, 1'b1,
      '{ST_OK, 1'b1, 1'b1}},
    '{1'b0, 1'b0, '{FN_CHECK,     32'hC0A8_0005, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b1,
      '{ST_BLOCKED, 1'b1, 1'b1}},
    '{1'b1, 1'b0, '{FN_CHECK,     32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0}, 1'b0, '0}
  };

  function automatic logic [31:0] net_mask(input logic [5:0] plen);
    if (plen >= PLEN_MAX) return 32'hFFFF_FFFF;
    if (plen == 6'd0) return 32'h0;
    return 32'hFFFF_FFFF << (32 - int'(plen));
  endfunction

  function automatic logic list_hit(input logic lst, input logic [31:0] addr);
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      if (ent_used[lst][i] && ent_plen[lst][i] <= PLEN_MAX &&
          ((ent_net[lst][i] ^ addr) & net_mask(ent_plen[lst][i])) == 32'h0) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int find_entry(input logic lst, input logic [31:0] addr,
                                    input logic [5:0] plen);
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      if (ent_used[lst][i] && ent_net[lst][i] == addr && ent_plen[lst][i] == plen) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic status_t list_add(input logic lst, input logic [31:0] addr,
                                       input logic [5:0] plen);
    if (find_entry(lst, addr, plen) >= 0) return ST_OK;
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      if (!ent_used[lst][i]) begin
        ent_used[lst][i] = 1'b1;
        ent_net[lst][i]  = addr;
        ent_plen[lst][i] = plen;
        list_on[lst]     = 1'b1;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic status_t list_remove(input logic lst, input logic [31:0] addr,
                                          input logic [5:0] plen);
    int idx;
    idx = find_entry(lst, addr, plen);
    if (idx >= 0) begin
      ent_used[lst][idx] = 1'b0;
      return ST_OK;
    end
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      if (ent_used[lst][i]) return ST_NOT_FOUND;
    end
    // miss on an empty list turns it off
    list_on[lst] = 1'b0;
    return ST_NOT_FOUND;
  endfunction

  function automatic acl_result_t acl_decide(input acl_req_t r);
    acl_result_t res;
    status_t st;
    st = ST_OK;
    case (r.func)
      FN_CHECK: begin
        if (list_on[LIST_BLOCK] && r.ip_present && list_hit(LIST_BLOCK, r.address)) begin
          st = ST_BLOCKED;
        end else if (list_on[LIST_ALLOW] && r.ip_present &&
                     !list_hit(LIST_ALLOW, r.address)) begin
          st = ST_NOT_ALLOWED;
        end else if (tok_check_on && !r.token_present) begin
          st = ST_NO_TOKEN;
        end else if (tok_check_on && !r.token_accepted) begin
          st = ST_INVALID_TOKEN;
        end
      end
      FN_ADD_ALLOW: st = list_add(LIST_ALLOW, r.address, r.pfx_len);
      FN_ADD_BLOCK: st = list_add(LIST_BLOCK, r.address, r.pfx_len);
      FN_REM_ALLOW: st = list_remove(LIST_ALLOW, r.address, r.pfx_len);
      FN_REM_BLOCK: st = list_remove(LIST_BLOCK, r.address, r.pfx_len);
      default: st = ST_OK;
    endcase
    res.status   = st;
    res.allow_on = list_on[LIST_ALLOW];
    res.block_on = list_on[LIST_BLOCK];
    return res;
  endfunction

  function automatic logic pick_entry(input logic lst, output logic [31:0] a,
                                      output logic [5:0] p);
    int slots[$];
    int k;
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      if (ent_used[lst][i]) slots.push_back(i);
    end
    if (slots.size() == 0) return 1'b0;
    k = slots[$urandom_range(0, slots.size() - 1)];
    a = ent_net[lst][k];
    p = ent_plen[lst][k];
    return 1'b1;
  endfunction

  function automatic logic [5:0] pick_plen();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 6'd0;
    if (r < 6) return 6'($urandom_range(33, 63));
    if (r < 12) return 6'($urandom_range(1, 7));
    if (r < 50) return 6'(8 * $urandom_range(1, 4));
    return 6'($urandom_range(8, 32));
  endfunction

  // Adds and removes draw from a small address pool so they collide with live entries;
  // checks land inside a stored prefix for up to half of draws, else near a pool address or random.
  function automatic acl_req_t make_req(input phase_mix_t mix);
    acl_req_t r;
    int sel;
    int k;
    logic lst;
    logic [31:0] a;
    logic [31:0] m;
    logic [5:0] p;
    r.address        = $urandom;
    r.pfx_len        = pick_plen();
    r.ip_present     = ($urandom_range(0, 6) != 0);
    r.token_present  = 1'($urandom_range(0, 1));
    r.token_accepted = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    k = 0;
    while (k < 5 && sel >= FUNC_CUTS[mix][k]) k++;
    r.func = (k < 5) ? 3'(k) : 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
    lst = (r.func == FN_ADD_BLOCK || r.func == FN_REM_BLOCK) ? LIST_BLOCK : LIST_ALLOW;
    case (r.func)
      FN_CHECK: begin
        sel = $urandom_range(0, 9);
        if (sel < 5 && pick_entry(sel[0] ? LIST_BLOCK : LIST_ALLOW, a, p)) begin
          m = net_mask(p);
          r.address = (a & m) | (r.address & ~m);
        end else if (sel < 8) begin
          r.address = net_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 255);
        end
      end
      FN_ADD_ALLOW, FN_ADD_BLOCK: begin
        if ($urandom_range(0, 9) == 0 && pick_entry(lst, a, p)) begin
          r.address = a;
          r.pfx_len = p;
        end else begin
          r.address = net_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 3);
        end
      end
      FN_REM_ALLOW, FN_REM_BLOCK: begin
        if ($urandom_range(0, 3) != 0 && pick_entry(lst, a, p)) begin
          r.address = a;
          r.pfx_len = p;
        end else begin
          r.address = net_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 3);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge with valid low.
  task automatic push_req(input acl_req_t r, input logic typed, input acl_result_t want);
    acl_result_t predicted;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 9)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_chan.func           = r.func;
    in_chan.address        = r.address;
    in_chan.pfx_len        = r.pfx_len;
    in_chan.ip_present     = r.ip_present;
    in_chan.token_present  = r.token_present;
    in_chan.token_accepted = r.token_accepted;
    in_chan.valid          = 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    predicted = acl_decide(r);
    verdict_q.push_back(typed ? want : predicted);
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  // Only while idle: hold off until every outstanding verdict is back.
  task automatic write_token_check(input logic v);
    in_chan.valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    tok_check_on = v;
  endtask

  initial begin : stimulus
    rst_n                  = 1'b0;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.func           = FN_CHECK;
    in_chan.address        = 32'h0;
    in_chan.pfx_len        = 6'd0;
    in_chan.ip_present     = 1'b0;
    in_chan.token_present  = 1'b0;
    in_chan.token_accepted = 1'b0;
    foreach (ent_used[l, i]) begin
      ent_used[l][i] = 1'b0;
      ent_net[l][i]  = 32'h0;
      ent_plen[l][i] = 6'd0;
    end
    list_on[LIST_ALLOW] = 1'b0;
    list_on[LIST_BLOCK] = 1'b0;
    tok_check_on        = 1'b0;
    foreach (net_pool[i]) net_pool[i] = $urandom;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) write_token_check(dir_rows[i].cfg_val);
      push_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_token_check(ph[0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_req(make_req(phase_mix_t'(ph % 3)), 1'b0, '0);
      end
    end

    in_chan.valid = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS ip_cidr_access_filter");
    end else begin
      $display("FAIL ip_cidr_access_filter");
    end
    $finish;
  end

  initial begin : result_sink
    rx_mode_t mode;
    int span;
    int tick;
    out_chan.ready = 1'b0;
    tick = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 128);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          RX_OPEN:     out_chan.ready = 1'b1;
          RX_RANDOM:   out_chan.ready = 1'($urandom_range(0, 1));
          RX_PERIODIC: out_chan.ready = (tick % 6) > 2;
          default:     out_chan.ready = (tick % 24) >= 20;   // long stalls
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    acl_result_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected transfer: status=%0d allow=%0b block=%0b", $time,
                 out_chan.status, out_chan.allow_list_on, out_chan.block_list_on);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_chan.status !== want.status || out_chan.allow_list_on !== want.allow_on ||
            out_chan.block_list_on !== want.block_on) begin
          $display("%0t mismatch: expected status=%0d allow=%0b block=%0b, got %0d %0b %0b",
                   $time, want.status, want.allow_on, want.block_on, out_chan.status,
                   out_chan.allow_list_on, out_chan.block_list_on);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("FAIL ip_cidr_access_filter");
    $finish;
  end

endmodule
